// ===== sv/thread_run_queue_scheduler_top_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the thread run queue scheduler
// Shared property forms, clocked on clk and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef THREAD_RUN_QUEUE_SCHEDULER_TOP_ASSERT_SVH
`define THREAD_RUN_QUEUE_SCHEDULER_TOP_ASSERT_SVH

// Same-cycle implication.
`define TRQS_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define TRQS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== sv/trqs_pkg.sv =====
// ----------------------------------------------------------------------------
// trqs_pkg
// Types and constants shared by the run queue scheduler controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package trqs_pkg;

	localparam int N_THREADS = 16;
	localparam int SLOT_W    = 4;
	localparam int OP_W      = 3;

	typedef enum logic [OP_W-1:0] {
		OP_CREATE = 3'd0,
		OP_RESUME = 3'd1,
		OP_RESCHED = 3'd2,
		OP_PAUSE  = 3'd3,
		OP_FINISH = 3'd4
	} op_t;

	typedef enum logic [1:0] {
		SLOT_FREE     = 2'd0,
		SLOT_PAUSED   = 2'd1,
		SLOT_RUNNING  = 2'd2,
		SLOT_FINISHED = 2'd3
	} slot_st_t;

	typedef enum logic [2:0] {
		C_IDLE,
		C_EXEC,
		C_PUSH,
		C_POP,
		C_DONE
	} ctl_state_t;

	typedef struct packed {
		logic load_in;
		logic exec;
		logic push;
		logic pop;
		logic load_out;
	} dp_cmd_t;

	typedef struct packed {
		logic resched;
		logic push_cur;
		logic out_busy;
	} dp_status_t;

endpackage

`default_nettype wire

// ===== sv/trqs_ctrl.sv =====
// ----------------------------------------------------------------------------
// trqs_ctrl
// Sequencer that steps one request through take-in, apply, tail insert and head
// pop when needed, and result load.
// ----------------------------------------------------------------------------
`default_nettype none

module trqs_ctrl (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                s_tvalid,
	output logic                     s_tready,
	input  wire trqs_pkg::dp_status_t status,
	output trqs_pkg::dp_cmd_t        cmd
);

	trqs_pkg::ctl_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= trqs_pkg::C_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		s_tready = 1'b0;
		cmd      = '0;
		case (state_q)
			trqs_pkg::C_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.load_in = 1'b1;
					state_d     = trqs_pkg::C_EXEC;
				end
			end
			trqs_pkg::C_EXEC: begin
				cmd.exec = 1'b1;
				if (status.push_cur) begin
					state_d = trqs_pkg::C_PUSH;
				end else if (status.resched) begin
					state_d = trqs_pkg::C_POP;
				end else begin
					state_d = trqs_pkg::C_DONE;
				end
			end
			trqs_pkg::C_PUSH: begin
				cmd.push = 1'b1;
				state_d  = trqs_pkg::C_POP;
			end
			trqs_pkg::C_POP: begin
				cmd.pop = 1'b1;
				state_d = trqs_pkg::C_DONE;
			end
			trqs_pkg::C_DONE: begin
				if (!status.out_busy) begin
					cmd.load_out = 1'b1;
					state_d      = trqs_pkg::C_IDLE;
				end
			end
			default: begin
				state_d = trqs_pkg::C_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

// ===== sv/trqs_datapath.sv =====
// ----------------------------------------------------------------------------
// trqs_datapath
// Slot status table, run queue links, queue pointers, current thread and the
// result register.
// ----------------------------------------------------------------------------
`default_nettype none

`include "thread_run_queue_scheduler_top_assert.svh"

module trqs_datapath (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire trqs_pkg::dp_cmd_t   cmd,
	output trqs_pkg::dp_status_t     status,
	input  wire logic [7:0]          s_tdata,
	output logic                     m_tvalid,
	input  wire logic                m_tready,
	output logic [7:0]               m_tdata
);

	localparam int SW = trqs_pkg::SLOT_W;

	logic [trqs_pkg::OP_W-1:0] op_q;
	logic [SW-1:0]             id_q;
	logic                      once_q;

	trqs_pkg::slot_st_t        slot_st_q [trqs_pkg::N_THREADS];
	logic [SW-1:0]             link_q [trqs_pkg::N_THREADS];
	logic [SW-1:0]             head_q, tail_q, cur_q;
	logic                      nonempty_q, cur_vld_q, reject_q;

	logic [SW-1:0]             out_id_q;
	logic                      out_cv_q, out_qe_q, out_st_q, out_vld_q;

	trqs_pkg::slot_st_t        id_st;
	logic                      in_range;
	logic                      st_we;
	logic [SW-1:0]             st_waddr;
	trqs_pkg::slot_st_t        st_wdata;
	logic                      link_we;
	logic [SW-1:0]             link_waddr, link_wdata;
	logic [SW-1:0]             head_d, tail_d, cur_d;
	logic                      nonempty_d, cur_vld_d, reject_d;

	assign id_st    = slot_st_q[id_q];
	assign in_range = (32'(id_q) < trqs_pkg::N_THREADS);

	always_comb begin
		status.resched  = 1'b0;
		status.push_cur = 1'b0;
		case (op_q)
			trqs_pkg::OP_RESUME: begin
				status.resched  = once_q;
				status.push_cur = once_q && cur_vld_q;
			end
			trqs_pkg::OP_RESCHED: begin
				status.resched  = 1'b1;
				status.push_cur = cur_vld_q;
			end
			trqs_pkg::OP_PAUSE, trqs_pkg::OP_FINISH: begin
				status.resched = cur_vld_q;
			end
			default: begin
			end
		endcase
		status.out_busy = out_vld_q && !m_tready;
	end

	always_comb begin
		st_we      = 1'b0;
		st_waddr   = id_q;
		st_wdata   = trqs_pkg::SLOT_PAUSED;
		link_we    = 1'b0;
		link_waddr = id_q;
		link_wdata = head_q;
		head_d     = head_q;
		tail_d     = tail_q;
		nonempty_d = nonempty_q;
		cur_d      = cur_q;
		cur_vld_d  = cur_vld_q;
		reject_d   = reject_q;
		if (cmd.exec) begin
			reject_d = 1'b0;
			case (op_q)
				trqs_pkg::OP_CREATE: begin
					if (in_range && (id_st == trqs_pkg::SLOT_FREE ||
							id_st == trqs_pkg::SLOT_FINISHED)) begin
						st_we = 1'b1;
					end else begin
						reject_d = 1'b1;
					end
				end
				trqs_pkg::OP_RESUME: begin
					if (in_range && id_st == trqs_pkg::SLOT_PAUSED) begin
						st_we    = 1'b1;
						st_wdata = trqs_pkg::SLOT_RUNNING;
						head_d   = id_q;
						if (!nonempty_q) begin
							tail_d     = id_q;
							nonempty_d = 1'b1;
						end else begin
							link_we = 1'b1;
						end
					end else begin
						reject_d = 1'b1;
					end
				end
				trqs_pkg::OP_RESCHED: begin
				end
				trqs_pkg::OP_PAUSE, trqs_pkg::OP_FINISH: begin
					if (cur_vld_q) begin
						st_we    = 1'b1;
						st_waddr = cur_q;
						st_wdata = (op_q == trqs_pkg::OP_PAUSE) ?
							trqs_pkg::SLOT_PAUSED : trqs_pkg::SLOT_FINISHED;
					end else begin
						reject_d = 1'b1;
					end
				end
				default: begin
					reject_d = 1'b1;
				end
			endcase
		end else if (cmd.push) begin
			tail_d = cur_q;
			if (!nonempty_q) begin
				head_d     = cur_q;
				nonempty_d = 1'b1;
			end else begin
				link_we    = 1'b1;
				link_waddr = tail_q;
				link_wdata = cur_q;
			end
		end else if (cmd.pop) begin
			if (nonempty_q) begin
				cur_d     = head_q;
				cur_vld_d = 1'b1;
				if (head_q == tail_q) begin
					nonempty_d = 1'b0;
				end else begin
					head_d = link_q[head_q];
				end
			end else begin
				cur_d     = '0;
				cur_vld_d = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < trqs_pkg::N_THREADS; i++) begin
				slot_st_q[i] <= trqs_pkg::SLOT_FREE;
			end
			head_q     <= '0;
			tail_q     <= '0;
			nonempty_q <= 1'b0;
			cur_q      <= '0;
			cur_vld_q  <= 1'b0;
			out_vld_q  <= 1'b0;
		end else begin
			if (st_we) begin
				slot_st_q[st_waddr] <= st_wdata;
			end
			head_q     <= head_d;
			tail_q     <= tail_d;
			nonempty_q <= nonempty_d;
			cur_q      <= cur_d;
			cur_vld_q  <= cur_vld_d;
			if (cmd.load_out) begin
				out_vld_q <= 1'b1;
			end else if (m_tready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (link_we) begin
			link_q[link_waddr] <= link_wdata;
		end
		if (cmd.load_in) begin
			op_q   <= s_tdata[2:0];
			id_q   <= s_tdata[6:3];
			once_q <= s_tdata[7];
		end
		reject_q <= reject_d;
		if (cmd.load_out) begin
			out_id_q <= cur_vld_q ? cur_q : '0;
			out_cv_q <= cur_vld_q;
			out_qe_q <= !nonempty_q;
			out_st_q <= reject_q;
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = {1'b0, out_st_q, out_qe_q, out_cv_q, out_id_q};

	`TRQS_ASSERT_NOW(a_push_running, cmd.push,
		cur_vld_q && slot_st_q[cur_q] == trqs_pkg::SLOT_RUNNING,
		"Tail insert of a current thread that is not running.")
	`TRQS_ASSERT_NOW(a_head_running, cmd.pop && nonempty_q,
		slot_st_q[head_q] == trqs_pkg::SLOT_RUNNING,
		"Head of the run queue is not a running thread.")
	`TRQS_ASSERT_NEXT(a_pop_current, cmd.pop && nonempty_q,
		cur_vld_q && slot_st_q[cur_q] == trqs_pkg::SLOT_RUNNING,
		"Popped thread did not become a running current thread.")

endmodule

`default_nettype wire

// ===== sv/thread_run_queue_scheduler_top.sv =====
// ----------------------------------------------------------------------------
// thread_run_queue_scheduler_top
// Round-robin thread scheduler over 16 slots with a linked run queue.
//
//   Channel  Direction  Contents
//   s_*      in         request: op, thread_id, resched_now
//   m_*      out        result: current_id, current_valid, queue_empty, status
//
// A request goes from acceptance to its result in the output register through
// these steps in order: take it in, apply it, move a still running current
// thread to the queue tail, pop the queue head, load the result. The tail
// insert and head pop steps are taken only when the request calls for them.
// Reset clears all slots to free, empties the queue and leaves no current
// thread. A result not yet taken holds the sequencer before the next load.
// ----------------------------------------------------------------------------
`default_nettype none

module thread_run_queue_scheduler_top (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       s_tvalid,
	output logic            s_tready,
	// [2:0] op, [6:3] thread_id, [7] resched_now
	input  wire logic [7:0] s_tdata,
	output logic            m_tvalid,
	input  wire logic       m_tready,
	// [3:0] current_id, [4] current_valid, [5] queue_empty, [6] status, [7] zero
	output logic [7:0]      m_tdata
);

	trqs_pkg::dp_cmd_t    cmd;
	trqs_pkg::dp_status_t status;

	trqs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.status   (status),
		.cmd      (cmd)
	);

	trqs_datapath u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.status   (status),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

endmodule

`default_nettype wire

// ===== sim/tb_thread_run_queue_scheduler_top.sv =====
// ----------------------------------------------------------------------------
// Testbench for thread_run_queue_scheduler_top
// Sends create, resume, reschedule, pause and finish requests, plus unused
// codes, and tracks slot states and the run queue in a local model. Every
// result is checked field by field against the model's prediction. Both
// stream sides stall at random, except during one long stretch.
// ----------------------------------------------------------------------------
module tb_thread_run_queue_scheduler_top;

	localparam int N_RANDOM = 1925;

	localparam logic [2:0] OP_SPARE_LO  = 3'd5;
	localparam logic [2:0] OP_SPARE_MID = 3'd6;
	localparam logic [2:0] OP_SPARE_HI  = 3'd7;

	typedef struct packed {
		logic                          pad;
		logic                          status;
		logic                          queue_empty;
		logic                          current_valid;
		logic [trqs_pkg::SLOT_W-1:0]   current_id;
	} sched_result_t;

	class run_queue_tracker;
		trqs_pkg::slot_st_t          slot_state [trqs_pkg::N_THREADS];
		logic [trqs_pkg::SLOT_W-1:0] link [trqs_pkg::N_THREADS];
		logic [trqs_pkg::SLOT_W-1:0] head;
		logic [trqs_pkg::SLOT_W-1:0] tail;
		logic [trqs_pkg::SLOT_W-1:0] cur;
		bit                queued;
		bit                cur_valid;
		sched_result_t     predicted_states [$];
		int unsigned       op_seen [8];
		int unsigned       rejects;
		int unsigned       checked;
		int unsigned       failures;

		function new();
			foreach (slot_state[i])
				slot_state[i] = trqs_pkg::SLOT_FREE;
			foreach (op_seen[i])
				op_seen[i] = 0;
			head = '0;
			tail = '0;
			cur = '0;
			queued = 0;
			cur_valid = 0;
			rejects = 0;
			checked = 0;
			failures = 0;
		endfunction

		// A still running current thread goes to the tail, then the head runs.
		function void rotate_run_queue();
			if (cur_valid && slot_state[cur] == trqs_pkg::SLOT_RUNNING) begin
				if (!queued) begin
					head = cur;
					tail = cur;
					queued = 1;
				end else begin
					link[tail] = cur;
					tail = cur;
				end
			end
			if (queued) begin
				cur = head;
				cur_valid = 1;
				if (head == tail)
					queued = 0;
				else
					head = link[head];
			end else begin
				cur = '0;
				cur_valid = 0;
			end
		endfunction

		function void note_request(logic [7:0] word);
			logic [trqs_pkg::OP_W-1:0]   op;
			logic [trqs_pkg::SLOT_W-1:0] id;
			logic              at_once;
			logic              reject;
			bit                in_range;
			sched_result_t     res;
			op = word[2:0];
			id = word[6:3];
			at_once = word[7];
			in_range = int'(id) < trqs_pkg::N_THREADS;
			reject = 1'b0;
			op_seen[op]++;
			case (op)
			trqs_pkg::OP_CREATE: begin
				if (in_range && (slot_state[id] == trqs_pkg::SLOT_FREE ||
						slot_state[id] == trqs_pkg::SLOT_FINISHED))
					slot_state[id] = trqs_pkg::SLOT_PAUSED;
				else
					reject = 1'b1;
			end
			trqs_pkg::OP_RESUME: begin
				if (in_range && slot_state[id] == trqs_pkg::SLOT_PAUSED) begin
					slot_state[id] = trqs_pkg::SLOT_RUNNING;
					if (!queued) begin
						head = id;
						tail = id;
						queued = 1;
					end else begin
						link[id] = head;
						head = id;
					end
				end else begin
					reject = 1'b1;
				end
				if (at_once)
					rotate_run_queue();
			end
			trqs_pkg::OP_RESCHED: begin
				rotate_run_queue();
			end
			trqs_pkg::OP_PAUSE, trqs_pkg::OP_FINISH: begin
				if (cur_valid) begin
					slot_state[cur] = (op == trqs_pkg::OP_PAUSE) ?
						trqs_pkg::SLOT_PAUSED : trqs_pkg::SLOT_FINISHED;
					rotate_run_queue();
				end else begin
					reject = 1'b1;
				end
			end
			default: begin
				reject = 1'b1;
			end
			endcase
			res.pad = 1'b0;
			res.status = reject;
			res.queue_empty = !queued;
			res.current_valid = cur_valid;
			res.current_id = cur_valid ? cur : '0;
			if (reject)
				rejects++;
			predicted_states.push_back(res);
		endfunction

		function void check_result(logic [7:0] word);
			sched_result_t got;
			sched_result_t want;
			got = word;
			checked++;
			if (predicted_states.size() == 0) begin
				failures++;
				if (failures <= 10)
					$display("Unexpected result %h with no request outstanding.", word);
				return;
			end
			want = predicted_states.pop_front();
			if (got.current_id !== want.current_id ||
					got.current_valid !== want.current_valid ||
					got.queue_empty !== want.queue_empty ||
					got.status !== want.status ||
					got.pad !== want.pad) begin
				failures++;
				if (failures <= 10)
					$display({"Mismatch on result %0d: expected id %0d valid %b empty %b ",
						"status %b pad %b, got id %0d valid %b empty %b status %b pad %b."},
						checked, want.current_id, want.current_valid, want.queue_empty,
						want.status, want.pad, got.current_id, got.current_valid,
						got.queue_empty, got.status, got.pad);
			end
		endfunction
	endclass

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       s_tvalid = 1'b0;
	logic       s_tready;
	logic [7:0] s_tdata = '0;
	logic       m_tvalid;
	logic       m_tready = 1'b0;
	logic [7:0] m_tdata;
	bit         steady = 0;

	run_queue_tracker tracker;

	thread_run_queue_scheduler_top uut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic logic [7:0] pack_request(logic [2:0] op, logic [3:0] id,
			logic at_once);
		return {at_once, id, op};
	endfunction

	task automatic send_request(logic [7:0] word);
		while (!steady && $urandom_range(99) < 11) begin
			@(negedge clk);
			s_tvalid <= 1'b0;
		end
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tdata <= word;
		do
			@(posedge clk);
		while (!s_tready);
		tracker.note_request(word);
	endtask

	// Most creates and resumes name a slot in a state where they apply.
	task automatic random_request();
		int          roll;
		logic [2:0]  op;
		logic [3:0]  id;
		int unsigned fits [$];
		roll = $urandom_range(99);
		if (roll < 22)
			op = trqs_pkg::OP_CREATE;
		else if (roll < 52)
			op = trqs_pkg::OP_RESUME;
		else if (roll < 76)
			op = trqs_pkg::OP_RESCHED;
		else if (roll < 86)
			op = trqs_pkg::OP_PAUSE;
		else if (roll < 95)
			op = trqs_pkg::OP_FINISH;
		else
			op = 3'($urandom_range(OP_SPARE_HI, OP_SPARE_LO));
		id = 4'($urandom_range(15));
		foreach (tracker.slot_state[i]) begin
			if (op == trqs_pkg::OP_CREATE &&
					(tracker.slot_state[i] == trqs_pkg::SLOT_FREE ||
					tracker.slot_state[i] == trqs_pkg::SLOT_FINISHED))
				fits.push_back(i);
			if (op == trqs_pkg::OP_RESUME && tracker.slot_state[i] == trqs_pkg::SLOT_PAUSED)
				fits.push_back(i);
		end
		if (fits.size() != 0 && $urandom_range(99) < 80)
			id = 4'(fits[$urandom_range(fits.size() - 1)]);
		send_request(pack_request(op, id, 1'($urandom_range(1))));
	endtask

	initial begin
		forever begin
			@(negedge clk);
			m_tready <= steady || ($urandom_range(99) >= 11);
		end
	end

	initial begin
		forever begin
			@(posedge clk);
			if (arst_n && m_tvalid && m_tready)
				tracker.check_result(m_tdata);
		end
	end

	initial begin
		tracker = new();
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		send_request(pack_request(trqs_pkg::OP_RESCHED, 4'd0, 1'b0));
		send_request(pack_request(trqs_pkg::OP_PAUSE, 4'd0, 1'b0));
		send_request(pack_request(trqs_pkg::OP_FINISH, 4'd15, 1'b1));
		send_request(pack_request(OP_SPARE_LO, 4'd15, 1'b1));
		send_request(pack_request(OP_SPARE_MID, 4'd0, 1'b0));
		send_request(pack_request(OP_SPARE_HI, 4'd10, 1'b1));
		send_request(pack_request(trqs_pkg::OP_RESUME, 4'd3, 1'b1));
		send_request(pack_request(trqs_pkg::OP_CREATE, 4'd0, 1'b0));
		send_request(pack_request(trqs_pkg::OP_CREATE, 4'd15, 1'b1));
		send_request(pack_request(trqs_pkg::OP_CREATE, 4'd0, 1'b0));
		send_request(pack_request(trqs_pkg::OP_RESUME, 4'd0, 1'b0));
		send_request(pack_request(trqs_pkg::OP_RESUME, 4'd3, 1'b1));
		send_request(pack_request(trqs_pkg::OP_CREATE, 4'd0, 1'b0));
		send_request(pack_request(trqs_pkg::OP_RESUME, 4'd15, 1'b1));
		send_request(pack_request(trqs_pkg::OP_RESCHED, 4'd7, 1'b1));
		send_request(pack_request(trqs_pkg::OP_RESUME, 4'd0, 1'b0));
		send_request(pack_request(trqs_pkg::OP_PAUSE, 4'd0, 1'b0));
		send_request(pack_request(trqs_pkg::OP_FINISH, 4'd0, 1'b0));
		send_request(pack_request(trqs_pkg::OP_FINISH, 4'd0, 1'b0));
		send_request(pack_request(trqs_pkg::OP_CREATE, 4'd15, 1'b0));
		send_request(pack_request(trqs_pkg::OP_RESUME, 4'd15, 1'b0));
		send_request(pack_request(trqs_pkg::OP_RESUME, 4'd0, 1'b0));
		send_request(pack_request(trqs_pkg::OP_RESCHED, 4'd0, 1'b0));
		send_request(pack_request(trqs_pkg::OP_RESCHED, 4'd0, 1'b0));
		send_request(pack_request(trqs_pkg::OP_RESCHED, 4'd0, 1'b0));

		for (int n = 0; n < N_RANDOM; n++) begin
			steady = (n >= 700 && n < 1000);
			random_request();
		end
		steady = 0;
		@(negedge clk);
		s_tvalid <= 1'b0;

		while (tracker.predicted_states.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);

		$display({"Applied %0d requests: create %0d, resume %0d, reschedule %0d, ",
			"pause %0d, finish %0d, unused codes %0d; %0d were rejected."},
			tracker.op_seen.sum(), tracker.op_seen[trqs_pkg::OP_CREATE],
			tracker.op_seen[trqs_pkg::OP_RESUME], tracker.op_seen[trqs_pkg::OP_RESCHED],
			tracker.op_seen[trqs_pkg::OP_PAUSE], tracker.op_seen[trqs_pkg::OP_FINISH],
			tracker.op_seen[OP_SPARE_LO] + tracker.op_seen[OP_SPARE_MID] +
			tracker.op_seen[OP_SPARE_HI], tracker.rejects);
		$display("Checked %0d results, %0d of them failed.", tracker.checked,
			tracker.failures);
		if (tracker.failures == 0 && tracker.predicted_states.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

	initial begin
		#2000000;
		$display("Run timed out.");
		$display("FAILURE");
		$finish;
	end

endmodule
